### rtl/mm2d_pkg.sv
package mm2d_pkg;

	localparam int unsigned VALUE_IN_W = 16;
	localparam int unsigned PRODUCT_W  = 35;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned DIM_W      = 4;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_LEFT  = 2'd0,
		CMD_LOAD_RIGHT = 2'd1,
		CMD_COMPUTE    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [DIM_W-1:0] lr;
		logic [DIM_W-1:0] kn;
		logic [DIM_W-1:0] rc;
	} dims_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} issue_t;

	typedef struct packed {
		logic             en;
		logic             from_acc;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             status;
		logic             last;
	} emit_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxd);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxd) begin
			r = maxd;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/mm2d_store.sv
module mm2d_store import mm2d_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned WIDTH = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/mm2d_mac.sv
module mm2d_mac import mm2d_pkg::*; #(
	parameter int unsigned SW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  issue_t                      issue,
	input  logic signed [SW-1:0]        a,
	input  logic signed [SW-1:0]        b,
	output logic signed [PRODUCT_W-1:0] acc,
	output logic                        acc_done
);

	issue_t                      tag_s1;
	issue_t                      tag_s2;
	logic signed [2*SW-1:0]      prod_s2;
	logic signed [PRODUCT_W-1:0] prod_ext;
	logic signed [PRODUCT_W-1:0] acc_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			prod_s2 <= a * b;
		end
	end

	assign prod_ext = {{(PRODUCT_W - 2 * SW){prod_s2[2*SW-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	assign acc      = acc_q;
	assign acc_done = done_q;

endmodule

### rtl/mm2d_seq.sv
module mm2d_seq import mm2d_pkg::*; #(
	parameter int unsigned MAX_DIM = 8,
	parameter int unsigned AW      = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       command,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  dims_t            dims,
	input  logic             out_free,
	input  logic             acc_done,
	output logic             in_ready,
	output logic             left_we,
	output logic             right_we,
	output logic [AW-1:0]    waddr,
	output logic [AW-1:0]    left_raddr,
	output logic [AW-1:0]    right_raddr,
	output issue_t           issue,
	output emit_t            emit
);

	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] r_q, r_d;
	logic [IDX_W-1:0] c_q, c_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             left_ok;
	logic             right_ok;
	logic             r_last;
	logic             c_last;
	logic             k_last;

	assign left_ok  = ({1'b0, row_index} < dims.lr) && ({1'b0, col_index} < dims.kn);
	assign right_ok = ({1'b0, row_index} < dims.kn) && ({1'b0, col_index} < dims.rc);
	assign r_last   = {1'b0, r_q} == dims.lr - DIM_W'(1);
	assign c_last   = {1'b0, c_q} == dims.rc - DIM_W'(1);
	assign k_last   = {1'b0, k_q} == dims.kn - DIM_W'(1);

	assign waddr       = AW'(int'(row_index) * MAX_DIM + int'(col_index));
	assign left_raddr  = AW'(int'(r_q) * MAX_DIM + int'(k_q));
	assign right_raddr = AW'(int'(k_q) * MAX_DIM + int'(c_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		c_d      = c_q;
		k_d      = k_q;
		in_ready = 1'b0;
		left_we  = 1'b0;
		right_we = 1'b0;
		issue    = '0;
		emit     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					case (cmd_t'(command))
						CMD_LOAD_LEFT: begin
							left_we     = left_ok;
							emit.en     = 1'b1;
							emit.row    = row_index;
							emit.col    = col_index;
							emit.status = !left_ok;
							emit.last   = 1'b1;
						end
						CMD_LOAD_RIGHT: begin
							right_we    = right_ok;
							emit.en     = 1'b1;
							emit.row    = row_index;
							emit.col    = col_index;
							emit.status = !right_ok;
							emit.last   = 1'b1;
						end
						CMD_COMPUTE: begin
							r_d     = '0;
							c_d     = '0;
							k_d     = '0;
							state_d = ST_ISSUE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ISSUE: begin
				issue.valid = 1'b1;
				issue.first = k_q == '0;
				issue.last  = k_last;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				if (acc_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit.en       = 1'b1;
					emit.from_acc = 1'b1;
					emit.row      = r_q;
					emit.col      = c_q;
					emit.last     = r_last && c_last;
					if (c_last) begin
						c_d = '0;
						if (r_last) begin
							state_d = ST_IDLE;
						end else begin
							r_d     = r_q + IDX_W'(1);
							state_d = ST_ISSUE;
						end
					end else begin
						c_d     = c_q + IDX_W'(1);
						state_d = ST_ISSUE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/matrix_multiply_2d.sv
// Load transactions are accepted one per cycle while the output register is free; each result
// is registered and appears in the cycle after acceptance. A compute transaction emits
// left_rows * right_cols results (sizes clamped to 1..MAX_DIM), each from inner_size store
// reads through the shared multiply-accumulate unit, a pipeline drain and an output register
// load. No new transaction is taken meanwhile. Reset clears the sequencer, the output valid
// and sets all three sizes to 8; the element stores are not cleared.
module matrix_multiply_2d import mm2d_pkg::*; #(
	parameter int unsigned MAX_DIM     = 8,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DIM_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [IDX_W-1:0]            row_index,
	input  logic [IDX_W-1:0]            col_index,
	input  logic signed [VALUE_IN_W-1:0] element_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [IDX_W-1:0]            out_row,
	output logic [IDX_W-1:0]            out_col,
	output logic signed [PRODUCT_W-1:0] product_value,
	output logic                        status,
	output logic                        last
);

	localparam int unsigned SW    = (VALUE_WIDTH < VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;
	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0]            left_rows_q;
	logic [DIM_W-1:0]            inner_size_q;
	logic [DIM_W-1:0]            right_cols_q;
	dims_t                       dims;
	logic                        out_valid_q;
	logic [IDX_W-1:0]            out_row_q;
	logic [IDX_W-1:0]            out_col_q;
	logic signed [PRODUCT_W-1:0] product_q;
	logic                        status_q;
	logic                        last_q;
	logic                        out_free;
	logic                        left_we;
	logic                        right_we;
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               left_raddr;
	logic [AW-1:0]               right_raddr;
	logic signed [SW-1:0]        left_rdata;
	logic signed [SW-1:0]        right_rdata;
	logic signed [PRODUCT_W-1:0] acc;
	logic                        acc_done;
	issue_t                      issue;
	emit_t                       emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= DIM_W'(8);
			inner_size_q <= DIM_W'(8);
			right_cols_q <= DIM_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				CFG_INNER_SIZE: inner_size_q <= cfg_data;
				CFG_RIGHT_COLS: right_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign dims.lr = eff_dim(left_rows_q, DIM_W'(MAX_DIM));
	assign dims.kn = eff_dim(inner_size_q, DIM_W'(MAX_DIM));
	assign dims.rc = eff_dim(right_cols_q, DIM_W'(MAX_DIM));

	assign out_free = !out_valid_q || out_ready;

	mm2d_seq #(
		.MAX_DIM(MAX_DIM),
		.AW     (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.command    (command),
		.row_index  (row_index),
		.col_index  (col_index),
		.dims       (dims),
		.out_free   (out_free),
		.acc_done   (acc_done),
		.in_ready   (in_ready),
		.left_we    (left_we),
		.right_we   (right_we),
		.waddr      (waddr),
		.left_raddr (left_raddr),
		.right_raddr(right_raddr),
		.issue      (issue),
		.emit       (emit)
	);

	mm2d_store #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.WIDTH(SW)
	) u_left_store (
		.clk  (clk),
		.we   (left_we),
		.waddr(waddr),
		.wdata(element_value[SW-1:0]),
		.raddr(left_raddr),
		.rdata(left_rdata)
	);

	mm2d_store #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.WIDTH(SW)
	) u_right_store (
		.clk  (clk),
		.we   (right_we),
		.waddr(waddr),
		.wdata(element_value[SW-1:0]),
		.raddr(right_raddr),
		.rdata(right_rdata)
	);

	mm2d_mac #(
		.SW(SW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.a       (left_rdata),
		.b       (right_rdata),
		.acc     (acc),
		.acc_done(acc_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.en) begin
			out_row_q <= emit.row;
			out_col_q <= emit.col;
			product_q <= emit.from_acc ? acc : '0;
			status_q  <= emit.status;
			last_q    <= emit.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = product_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule

### rtl/mm2d_checker.sv
module mm2d_checker import mm2d_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  command,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [IDX_W-1:0]            out_row,
	input logic [IDX_W-1:0]            out_col,
	input logic signed [PRODUCT_W-1:0] product_value,
	input logic                        status,
	input logic                        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(product_value) && $stable(status) && $stable(last))
		else $error("Output transaction changed while stalled.");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_LOAD_LEFT || command == CMD_LOAD_RIGHT)
			|=> out_valid && last && product_value == '0)
		else $error("Load transaction did not produce its result in the next cycle.");

	a_status_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && product_value == '0)
		else $error("Error status on a result that is not a load result.");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_COMPUTE |=> !in_ready)
		else $error("Input accepted right after a compute transaction.");

endmodule

bind matrix_multiply_2d mm2d_checker u_mm2d_checker (.*);
